// ===== design/cait_pkg.sv =====
// shared types and constants for the cpu affinity id table
package cait_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W      = 32;
    localparam int ROUTE_W     = 24;
    localparam int MASKED_W    = 40;

    typedef enum logic [1:0] {
        OP_ASSIGN = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // search token that walks down the row of cells
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic              full;
        logic [WORD_W-1:0] key;
        logic [IDX_W-1:0]  rd_idx;
        logic              id_hit;
        logic [IDX_W-1:0]  id_num;
        logic              rt_hit;
        logic [WORD_W-1:0] data;
    } t_tok;

    // counts and route write broadcast to every cell
    typedef struct packed {
        logic [CNT_W-1:0]   cpu_total;
        logic [CNT_W-1:0]   route_total;
        logic               rt_we;
        logic [IDX_W-1:0]   rt_widx;
        logic [ROUTE_W-1:0] rt_wdata;
    } t_ctl;

    function automatic logic [WORD_W-1:0] pack_aff(input logic [63:0] id);
        return {id[39:32], id[23:0]};
    endfunction

endpackage

// ===== design/cpu_affinity_id_table_core.sv =====
// top level of the cpu affinity id table
//
// Command channel: a transaction is taken at the rising edge where start is
// high and busy is low. i_opcode selects assign, lookup or read; assign and
// lookup use i_affinity_ident, read uses i_cpu_index.
// The command token walks one cell per cycle down a row of MAX_ENTRIES cells,
// each holding one identifier word and one cluster route. The result appears
// on the o_ ports with o_valid high for one cycle, once the token has left the
// last cell and been registered; busy is high from the accepting edge until
// then and low again in the cycle that o_valid is high, so a new transaction
// can be taken in the cycle that the result of the one before it is shown.
// o_cpus_known and o_routes_known always show the current counts and change
// only with a result.
// Reset (synchronous, active low) clears both counts and every stored
// identifier; no result is pending afterwards. The receiver cannot stall:
// each result is taken in the cycle it is shown.
module cpu_affinity_id_table_core import cait_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_opcode,
    input  logic [63:0]         i_affinity_ident,
    input  logic [IDX_W-1:0]    i_cpu_index,
    output logic                o_valid,
    output logic [IDX_W-1:0]    o_cpu_number,
    output logic                o_hit,
    output logic                o_table_full,
    output logic [MASKED_W-1:0] o_masked_ident,
    output logic [CNT_W-1:0]    o_cpus_known,
    output logic [CNT_W-1:0]    o_routes_known
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cpu_total;
    logic [CNT_W-1:0]    n_cpu_total;
    logic [CNT_W-1:0]    r_route_total;
    logic [CNT_W-1:0]    n_route_total;
    logic                r_valid;
    logic [IDX_W-1:0]    r_number;
    logic [IDX_W-1:0]    n_number;
    logic                r_hit;
    logic                n_hit;
    logic                r_full;
    logic                n_full;
    logic [MASKED_W-1:0] r_masked;
    logic [MASKED_W-1:0] n_masked;
    logic                w_accept;
    t_ctl                w_ctl;
    t_tok                w_tok [MAX_ENTRIES+1];
    t_tok                w_tail;

    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].vld    = w_accept;
        w_tok[0].op     = t_op'(i_opcode);
        w_tok[0].full   = (r_cpu_total == CNT_W'(MAX_ENTRIES));
        w_tok[0].key    = pack_aff(i_affinity_ident);
        w_tok[0].rd_idx = (CNT_W'(i_cpu_index) >= r_cpu_total) ? '0 : i_cpu_index;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        cait_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_ctl      (w_ctl),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[MAX_ENTRIES];

    always_comb begin
        w_ctl.cpu_total   = r_cpu_total;
        w_ctl.route_total = r_route_total;
        w_ctl.rt_we       = w_tail.vld && (w_tail.op == OP_ASSIGN) && !w_tail.full &&
                            !w_tail.rt_hit && (r_route_total < CNT_W'(MAX_ENTRIES));
        w_ctl.rt_widx     = r_route_total[IDX_W-1:0];
        w_ctl.rt_wdata    = w_tail.key[WORD_W-1:WORD_W-ROUTE_W];
    end

    always_comb begin
        n_state       = r_state;
        n_cpu_total   = r_cpu_total;
        n_route_total = r_route_total;
        n_number      = '0;
        n_hit         = 1'b0;
        n_full        = 1'b0;
        n_masked      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_tail.vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_tail.vld) begin
            case (w_tail.op)
                OP_ASSIGN: begin
                    if (w_tail.full) begin
                        n_full = 1'b1;
                    end else begin
                        n_number    = r_cpu_total[IDX_W-1:0];
                        n_hit       = 1'b1;
                        n_cpu_total = r_cpu_total + 1'b1;
                        if (w_ctl.rt_we) begin
                            n_route_total = r_route_total + 1'b1;
                        end
                    end
                end
                OP_LOOKUP: begin
                    n_number = w_tail.id_hit ? w_tail.id_num : '0;
                    n_hit    = w_tail.id_hit;
                end
                OP_READ: begin
                    n_masked = {w_tail.data[31:24], 8'h00, w_tail.data[23:0]};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cpu_total   <= '0;
            r_route_total <= '0;
            r_valid       <= 1'b0;
            r_number      <= '0;
            r_hit         <= 1'b0;
            r_full        <= 1'b0;
            r_masked      <= '0;
        end else begin
            r_state       <= n_state;
            r_cpu_total   <= n_cpu_total;
            r_route_total <= n_route_total;
            r_valid       <= w_tail.vld;
            r_number      <= n_number;
            r_hit         <= n_hit;
            r_full        <= n_full;
            r_masked      <= n_masked;
        end
    end

    assign busy           = (r_state == S_RUN);
    assign o_valid        = r_valid;
    assign o_cpu_number   = r_number;
    assign o_hit          = r_hit;
    assign o_table_full   = r_full;
    assign o_masked_ident = r_masked;
    assign o_cpus_known   = r_cpu_total;
    assign o_routes_known = r_route_total;

endmodule

// ===== design/cait_cell.sv =====
// one table cell: holds one identifier word and one route, compares the passing token
module cait_cell import cait_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_ctl             i_ctl,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    logic [WORD_W-1:0]  r_word;
    logic [WORD_W-1:0]  n_word;
    logic [ROUTE_W-1:0] r_route;
    t_tok               r_tok;
    t_tok               n_tok;
    logic [CNT_W-1:0]   w_idx_ext;

    assign w_idx_ext = CNT_W'(i_cell_idx);

    always_comb begin
        n_tok  = i_tok;
        n_word = r_word;
        if (i_tok.vld) begin
            case (i_tok.op)
                OP_ASSIGN: begin
                    if (!i_tok.full && (w_idx_ext == i_ctl.cpu_total)) begin
                        n_word = i_tok.key;
                    end
                    if ((w_idx_ext < i_ctl.route_total) &&
                        (r_route == i_tok.key[WORD_W-1:WORD_W-ROUTE_W])) begin
                        n_tok.rt_hit = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    if (!i_tok.id_hit && (w_idx_ext < i_ctl.cpu_total) &&
                        (r_word == i_tok.key)) begin
                        n_tok.id_hit = 1'b1;
                        n_tok.id_num = i_cell_idx;
                    end
                end
                OP_READ: begin
                    if (i_tok.rd_idx == i_cell_idx) begin
                        n_tok.data = r_word;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_tok  <= '0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    // route entries are only read below the route count, so no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.rt_we && (i_ctl.rt_widx == i_cell_idx)) begin
            r_route <= i_ctl.rt_wdata;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/cait_checker.sv =====
// port level checks for the cpu affinity id table, bound to the top level
module cait_checker import cait_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic                o_hit,
    input logic                o_table_full,
    input logic [CNT_W-1:0]    o_cpus_known,
    input logic [CNT_W-1:0]    o_routes_known
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result is only shown once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // a rejected assign only happens on a full table
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_hit && (o_cpus_known == CNT_W'(MAX_ENTRIES))))
        else $error("table full flag without a full table");

    // counts move only together with a result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_cpus_known != $past(o_cpus_known)) ||
         (o_routes_known != $past(o_routes_known))) |-> o_valid)
        else $error("count changed without a result");

    // never more routes than cpus
    a_route_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_routes_known <= o_cpus_known)
        else $error("route count above cpu count");

endmodule

bind cpu_affinity_id_table_core cait_checker u_cait_checker (.*);
